// ===== rtl/gaussian_pyramid_downsample_macros.svh =====
// Assertion macros used by the gaussian pyramid downsample RTL.
`ifndef GAUSSIAN_PYRAMID_DOWNSAMPLE_MACROS_SVH
`define GAUSSIAN_PYRAMID_DOWNSAMPLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gpd assertion failed");
`define GPD_ASSERT_NEXT(lbl, a, b) `GPD_ASSERT(lbl, (a) |=> (b))
`else
`define GPD_ASSERT(lbl, prop)
`define GPD_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ===== rtl/gpd_pkg.sv =====
// Types, constants and tap weights for the gaussian pyramid downsample block.
package gpd_pkg;

  localparam int VSUM_W = 21;
  localparam int HSUM_W = 25;
  localparam int QDEPTH = 4;
  localparam int QCNT_W = 3;
  localparam int ROW_SLOTS = 4;

  localparam logic FMT_U8_CEIL = 1'b0;
  localparam logic FMT_S16_TRUNC = 1'b1;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_CHANNEL_COUNT,
    REG_PIXEL_FORMAT
  } cfg_reg_e;

  // Tap pattern: interior, folded at the left/top edge, folded at the right/bottom edge.
  typedef enum logic [1:0] {
    TAP_NORMAL,
    TAP_LEFT,
    TAP_RIGHT
  } tap_mode_e;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [15:0] frame_height;
    logic [1:0]  channel_count;
    logic        pixel_format;
  } cfg_t;

  typedef struct packed {
    logic signed [VSUM_W-1:0] vsum;
    logic [1:0]               ch;
    tap_mode_e                hmode;
    logic                     emit;
    logic                     last;
  } q_entry_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  // Weight of the sample b positions back from the newest one (mirroring folded in).
  function automatic logic [3:0] tap_weight(tap_mode_e m, logic [2:0] b);
    logic [3:0] w;
    w = 4'd0;
    case (m)
      TAP_NORMAL: begin
        case (b)
          3'd0, 3'd4: w = 4'd1;
          3'd1, 3'd3: w = 4'd4;
          3'd2:       w = 4'd6;
          default:    w = 4'd0;
        endcase
      end
      TAP_LEFT: begin
        case (b)
          3'd0:    w = 4'd2;
          3'd1:    w = 4'd8;
          3'd2:    w = 4'd6;
          default: w = 4'd0;
        endcase
      end
      TAP_RIGHT: begin
        case (b)
          3'd0:    w = 4'd4;
          3'd1:    w = 4'd7;
          3'd2:    w = 4'd4;
          3'd3:    w = 4'd1;
          default: w = 4'd0;
        endcase
      end
      default: w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/gpd_if.sv =====
// Stream and configuration interfaces of the gaussian pyramid downsample block.
interface gpd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_sample;
  modport source (output valid, in_sample, input ready);
  modport sink (input valid, in_sample, output ready);
endinterface

interface gpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_sample;
  logic               frame_last;
  modport source (output valid, out_sample, frame_last, input ready);
  modport sink (input valid, out_sample, frame_last, output ready);
endinterface

interface gpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  modport source (output valid, cfg_index, cfg_data, input ready);
  modport sink (input valid, cfg_index, cfg_data, output ready);
endinterface

// ===== rtl/gpd_front.sv =====
// Front end: raster position tracking, line memories and vertical filter sum.
module gpd_front import gpd_pkg::*; #(
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_CHANNELS = 3,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  gpd_in_if.sink   in_if,
  input  q_stat_t  stat_i,
  output logic     push_o,
  output q_entry_t entry_o
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ADDR_W = COL_W + CH_W;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int WL_W   = COL_W + 1;

  logic [COL_W-1:0] col_q;
  logic [15:0]      row_q;
  logic [1:0]       ch_q;

  logic [WL_W-1:0]  w_eff;
  logic [15:0]      h_eff;
  logic [1:0]       c_eff;
  logic [COL_W-1:0] col;
  logic [15:0]      row;
  logic [1:0]       ch;
  logic             accept;
  logic             last_col, last_row, last_ch;
  logic             row_emit, col_emit;
  tap_mode_e        vmode, hmode;
  logic signed [15:0] cur;
  logic [ADDR_W-1:0] addr;
  logic [1:0]       slot;

  logic [SAMPLE_BITS-1:0] rd_q [ROW_SLOTS];
  logic               b_valid_q;
  logic signed [15:0] cur_q;
  logic               row_emit_q, emit_q, last_q;
  tap_mode_e          vmode_q, hmode_q;
  logic [1:0]         ch_b_q;
  logic [1:0]         slot_q;

  logic signed [VSUM_W-1:0] v [5];
  logic signed [VSUM_W-1:0] vsum;

  always_comb begin
    if (cfg_i.frame_width < 13'd4) begin
      w_eff = WL_W'(4);
    end else if (32'(cfg_i.frame_width) > MAX_WIDTH) begin
      w_eff = WL_W'(MAX_WIDTH);
    end else begin
      w_eff = WL_W'(cfg_i.frame_width);
    end
    h_eff = (cfg_i.frame_height < 16'd4) ? 16'd4 : cfg_i.frame_height;
    if (cfg_i.channel_count == 2'd0) begin
      c_eff = 2'd1;
    end else if (32'(cfg_i.channel_count) > MAX_CHANNELS) begin
      c_eff = 2'(MAX_CHANNELS);
    end else begin
      c_eff = cfg_i.channel_count;
    end
  end

  // Positions left out of range by a configuration change restart at zero.
  assign col = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
  assign row = (row_q >= h_eff) ? 16'd0 : row_q;
  assign ch  = (ch_q >= c_eff) ? 2'd0 : ch_q;

  assign last_col = ({1'b0, col} == (w_eff - WL_W'(1)));
  assign last_row = (row == (h_eff - 16'd1));
  assign last_ch  = (ch == (c_eff - 2'd1));

  always_comb begin
    row_emit = (!row[0] && (row >= 16'd2)) || (!h_eff[0] && last_row);
    col_emit = (!col[0] && (col >= COL_W'(2))) || (!w_eff[0] && last_col);
    if (row[0]) begin
      vmode = TAP_RIGHT;
    end else if (row == 16'd2) begin
      vmode = TAP_LEFT;
    end else begin
      vmode = TAP_NORMAL;
    end
    if (col[0]) begin
      hmode = TAP_RIGHT;
    end else if (col == COL_W'(2)) begin
      hmode = TAP_LEFT;
    end else begin
      hmode = TAP_NORMAL;
    end
  end

  assign cur    = 16'($signed(in_if.in_sample[SAMPLE_BITS-1:0]));
  assign addr   = {col, ch[CH_W-1:0]};
  assign slot   = row[1:0];
  assign accept = in_if.valid && in_if.ready;

  // Credit check: the queue must hold everything already in flight.
  assign in_if.ready = (int'(stat_i.count) + int'(b_valid_q)) < QDEPTH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      ch_q      <= '0;
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= accept;
      if (accept) begin
        if (last_ch) begin
          ch_q <= 2'd0;
          if (last_col) begin
            col_q <= '0;
            row_q <= last_row ? 16'd0 : row + 16'd1;
          end else begin
            col_q <= col + COL_W'(1);
            row_q <= row;
          end
        end else begin
          ch_q  <= ch + 2'd1;
          col_q <= col;
          row_q <= row;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q      <= cur;
      row_emit_q <= row_emit;
      emit_q     <= row_emit && col_emit;
      last_q     <= last_row && last_col && last_ch;
      vmode_q    <= vmode;
      hmode_q    <= hmode;
      ch_b_q     <= ch;
      slot_q     <= slot;
    end
  end

  // One line memory per row slot; read-first so row-4 is seen while row is written.
  for (genvar s = 0; s < ROW_SLOTS; s++) begin : g_slot
    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    always_ff @(posedge clk_i) begin
      if (accept) begin
        if (slot == 2'(s)) begin
          mem[addr] <= cur[SAMPLE_BITS-1:0];
        end
        rd_q[s] <= mem[addr];
      end
    end
  end

  // Rows with zero weight are skipped so unwritten slots never reach the sum.
  always_comb begin
    v[0] = VSUM_W'(cur_q);
    for (int b = 1; b < 5; b++) begin
      v[b] = VSUM_W'($signed(rd_q[slot_q - 2'(b)]));
    end
    vsum = '0;
    if (row_emit_q) begin
      for (int b = 0; b < 5; b++) begin
        if (tap_weight(vmode_q, 3'(b)) != 4'd0) begin
          vsum = vsum + v[b] * $signed({17'd0, tap_weight(vmode_q, 3'(b))});
        end
      end
    end
  end

  assign push_o        = b_valid_q;
  assign entry_o.vsum  = vsum;
  assign entry_o.ch    = ch_b_q;
  assign entry_o.hmode = hmode_q;
  assign entry_o.emit  = emit_q;
  assign entry_o.last  = last_q;

endmodule

// ===== rtl/gpd_queue.sv =====
// Short queue between the front and back ends.
module gpd_queue import gpd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output logic     valid_o,
  output q_entry_t entry_o,
  output q_stat_t  stat_o
);

`include "gaussian_pyramid_downsample_macros.svh"

  localparam int PTR_W = $clog2(QDEPTH);

  q_entry_t          slots_q [QDEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [QCNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= entry_i;
    end
  end

  assign valid_o      = (count_q != '0);
  assign entry_o      = slots_q[rd_q];
  assign stat_o.count = count_q;

  `GPD_ASSERT(a_no_overflow, !(push_i && (count_q == QCNT_W'(QDEPTH))))
  `GPD_ASSERT(a_no_underflow, !(pop_i && (count_q == '0)))
  `GPD_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + QCNT_W'(1))

endmodule

// ===== rtl/gpd_back.sv =====
// Back end: per-channel horizontal window, horizontal sum, rounding, output register.
module gpd_back import gpd_pkg::*; #(
  parameter int MAX_CHANNELS = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pixel_format_i,
  input  logic      valid_i,
  input  q_entry_t  entry_i,
  output logic      pop_o,
  gpd_out_if.source out_if
);

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic signed [VSUM_W-1:0] hwin_q [MAX_CHANNELS][5];
  logic signed [VSUM_W-1:0] win [5];
  logic signed [HSUM_W-1:0] hsum, up, dn;
  logic signed [15:0]       res;
  logic [CH_W-1:0]          chi;

  logic               out_valid_q;
  logic signed [15:0] sample_q;
  logic               last_q;

  assign chi   = entry_i.ch[CH_W-1:0];
  assign pop_o = valid_i && (!out_valid_q || out_if.ready);

  always_comb begin
    win[0] = entry_i.vsum;
    for (int k = 1; k < 5; k++) begin
      win[k] = hwin_q[chi][k-1];
    end
    hsum = '0;
    for (int k = 0; k < 5; k++) begin
      hsum = hsum + HSUM_W'(win[k]) * $signed({21'd0, tap_weight(entry_i.hmode, 3'(k))});
    end
    up = (hsum + HSUM_W'(255)) >>> 8;
    dn = hsum >>> 8;
    if (pixel_format_i == FMT_U8_CEIL) begin
      if (hsum <= 0) begin
        res = 16'sd0;
      end else if (up > HSUM_W'(255)) begin
        res = 16'sd255;
      end else begin
        res = 16'(up);
      end
    end else begin
      res = (hsum < 0) ? 16'(up) : 16'(dn);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int k = 0; k < 5; k++) begin
        hwin_q[chi][k] <= win[k];
      end
      if (entry_i.emit) begin
        sample_q <= res;
        last_q   <= entry_i.last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && entry_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.out_sample = sample_q;
  assign out_if.frame_last = last_q;

endmodule

// ===== rtl/gaussian_pyramid_downsample.sv =====
// Top level of the gaussian pyramid downsample block.
// Gaussian pyramid reduce (5x5 binomial 1-4-6-4-1, /256, mirrored borders):
// takes one interleaved channel sample per clock in raster order and emits
// the floor(W/2) x floor(H/2) halved image. Throughput is one input sample
// per clock while the queue has room, sustained across rows and frames;
// every transfer on the output side is one filtered sample, and frame_last
// marks the final one. A result passes from the accepting edge through the
// line memory read, the vertical sum into the queue and the horizontal sum
// into the output register. Four line memories, one per buffered row, are
// each read once per accepted sample, and only the current row's one is
// written; their contents are undefined after reset and every read the
// filter makes in a frame hits a row written earlier in that frame. A
// four-entry queue decouples the front end from the output so that output
// stalls back-pressure the input only once the queue and the vertical sum
// stage together hold four samples. Configuration registers must be written
// through the cfg channel only while idle; the block does not enforce this:
// 0 frame_width, 1 frame_height, 2 channel_count, 3 pixel_format.
module gaussian_pyramid_downsample import gpd_pkg::*; #(
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_CHANNELS = 3,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gpd_cfg_if.sink   cfg_if,
  gpd_in_if.sink    in_if,
  gpd_out_if.source out_if
);

  cfg_t     cfg_q;
  logic     push, pop, q_valid;
  q_entry_t push_entry, pop_entry;
  q_stat_t  q_stat;

  // Config channel never stalls.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width   <= 13'd640;
      cfg_q.frame_height  <= 16'd480;
      cfg_q.channel_count <= 2'd3;
      cfg_q.pixel_format  <= FMT_U8_CEIL;
    end else if (cfg_if.valid) begin
      case (cfg_reg_e'(cfg_if.cfg_index))
        REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_if.cfg_data[12:0];
        REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_if.cfg_data;
        REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_if.cfg_data[1:0];
        REG_PIXEL_FORMAT:  cfg_q.pixel_format  <= cfg_if.cfg_data[0];
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  // Front: positions, line memories, vertical sums.
  gpd_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .in_if   (in_if),
    .stat_i  (q_stat),
    .push_o  (push),
    .entry_o (push_entry)
  );

  gpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry),
    .stat_o  (q_stat)
  );

  // Back: horizontal window and rounding.
  gpd_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pixel_format_i (cfg_q.pixel_format),
    .valid_i        (q_valid),
    .entry_i        (pop_entry),
    .pop_o          (pop),
    .out_if         (out_if)
  );

endmodule
